>>> rtl/multicast_group_membership_table_defines.svh
// Assertion macros for the port-level checker of the multicast group table.
`ifndef MULTICAST_GROUP_MEMBERSHIP_TABLE_DEFINES_SVH
`define MULTICAST_GROUP_MEMBERSHIP_TABLE_DEFINES_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is active.
`define MCGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define MCGT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/mcgt_pkg.sv
// Shared constants, codes and types of the multicast group membership table.
`default_nettype none

package mcgt_pkg;

  localparam int unsigned NUM_GROUPS_DEF     = 16;
  localparam int unsigned GROUP_CAPACITY_DEF = 16;
  localparam int unsigned NUM_LINKS          = 64;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned GROUP_W  = 4;
  localparam int unsigned LINK_W   = 6;
  localparam int unsigned STATUS_W = 3;

  localparam logic [ACTION_W-1:0] ACT_JOIN  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LEAVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FAN   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_PURGE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTMEM  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MEMBER  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd6;

  // One result word handed from the sequencer to the output register.
  typedef struct packed {
    logic                vld;
    logic [STATUS_W-1:0] status;
    logic [LINK_W-1:0]   member_link;
    logic                last;
  } mcgt_res_t;

  function automatic int unsigned clog2_min1(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/multicast_group_membership_table.sv
// Multicast group membership table: member and count RAMs, sequencer and output register.
// Join and leave read the group's count, then scan its member row for the link; leave then
// moves the row's last member into the freed slot. Fan out reads and answers each member.
// Purge walks every group, with the slot move where the link is found. The input
// reopens once the final result word is loaded, so the table takes one item at a time.
// Reset clears the count valid bits and the sequencer; member slots are read only below a count.
`default_nettype none

module multicast_group_membership_table #(
  parameter int unsigned NUM_GROUPS     = mcgt_pkg::NUM_GROUPS_DEF,
  parameter int unsigned GROUP_CAPACITY = mcgt_pkg::GROUP_CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mcgt_pkg::ACTION_W-1:0]   action_i,
  input  logic [mcgt_pkg::GROUP_W-1:0]    group_i,
  input  logic [mcgt_pkg::LINK_W-1:0]     link_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mcgt_pkg::STATUS_W-1:0]   status_o,
  output logic [mcgt_pkg::LINK_W-1:0]     member_link_o,
  output logic                            last_o
);
  import mcgt_pkg::*;

  localparam int unsigned GW  = clog2_min1(NUM_GROUPS);
  localparam int unsigned MAW = clog2_min1(NUM_GROUPS * GROUP_CAPACITY);
  localparam int unsigned CW  = $clog2(GROUP_CAPACITY + 1);

  // Member RAM: one row of GROUP_CAPACITY link handles per group.
  logic              m_we;
  logic [MAW-1:0]    m_waddr;
  logic [LINK_W-1:0] m_wdata;
  logic              m_re;
  logic [MAW-1:0]    m_raddr;
  logic [LINK_W-1:0] m_rdata;

  // Count RAM: one member count per group, valid bits live in the sequencer.
  logic          c_we;
  logic [GW-1:0] c_addr;
  logic [CW-1:0] c_wdata;
  logic          c_re;
  logic [CW-1:0] c_rdata;

  mcgt_res_t emit;
  logic      out_free;

  // Output register. A word waits here while the input side is already free again.
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [LINK_W-1:0]   member_link_q;
  logic                last_q;

  assign out_free = !out_valid_q || !out_stall_i;

  mcgt_seq #(
    .NUM_GROUPS    (NUM_GROUPS),
    .GROUP_CAPACITY(GROUP_CAPACITY)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i  (action_i),
    .group_i   (group_i),
    .link_i    (link_i),
    .out_free_i(out_free),
    .emit_o    (emit),
    .m_we_o    (m_we),
    .m_waddr_o (m_waddr),
    .m_wdata_o (m_wdata),
    .m_re_o    (m_re),
    .m_raddr_o (m_raddr),
    .m_rdata_i (m_rdata),
    .c_we_o    (c_we),
    .c_addr_o  (c_addr),
    .c_wdata_o (c_wdata),
    .c_re_o    (c_re),
    .c_rdata_i (c_rdata)
  );

  mcgt_ram #(
    .WIDTH(LINK_W),
    .DEPTH(NUM_GROUPS * GROUP_CAPACITY)
  ) u_member_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .re_i   (m_re),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  mcgt_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_GROUPS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_addr),
    .wdata_i(c_wdata),
    .re_i   (c_re),
    .raddr_i(c_addr),
    .rdata_o(c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.vld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The sequencer only offers a word when the register is free, so loading is safe.
  always_ff @(posedge clk_i) begin
    if (emit.vld) begin
      status_q      <= emit.status;
      member_link_q <= emit.member_link;
      last_q        <= emit.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign member_link_o = member_link_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

>>> rtl/mcgt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mcgt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [mcgt_pkg::clog2_min1(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [mcgt_pkg::clog2_min1(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);
  import mcgt_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mcgt_seq.sv
// Sequencer and shared link comparator that walks one group's member row per step.
`default_nettype none

module mcgt_seq #(
  parameter int unsigned NUM_GROUPS     = mcgt_pkg::NUM_GROUPS_DEF,
  parameter int unsigned GROUP_CAPACITY = mcgt_pkg::GROUP_CAPACITY_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [mcgt_pkg::ACTION_W-1:0]          action_i,
  input  logic [mcgt_pkg::GROUP_W-1:0]           group_i,
  input  logic [mcgt_pkg::LINK_W-1:0]            link_i,
  input  logic                                   out_free_i,
  output mcgt_pkg::mcgt_res_t                    emit_o,
  output logic                                   m_we_o,
  output logic [mcgt_pkg::clog2_min1(NUM_GROUPS*GROUP_CAPACITY)-1:0] m_waddr_o,
  output logic [mcgt_pkg::LINK_W-1:0]            m_wdata_o,
  output logic                                   m_re_o,
  output logic [mcgt_pkg::clog2_min1(NUM_GROUPS*GROUP_CAPACITY)-1:0] m_raddr_o,
  input  logic [mcgt_pkg::LINK_W-1:0]            m_rdata_i,
  output logic                                   c_we_o,
  output logic [mcgt_pkg::clog2_min1(NUM_GROUPS)-1:0] c_addr_o,
  output logic [$clog2(GROUP_CAPACITY+1)-1:0]    c_wdata_o,
  output logic                                   c_re_o,
  input  logic [$clog2(GROUP_CAPACITY+1)-1:0]    c_rdata_i
);
  import mcgt_pkg::*;

  localparam int unsigned GW  = clog2_min1(NUM_GROUPS);
  localparam int unsigned MAW = clog2_min1(NUM_GROUPS * GROUP_CAPACITY);
  localparam int unsigned CW  = $clog2(GROUP_CAPACITY + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CNT   = 4'd1;
  localparam logic [3:0] S_CNTW  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_LRD   = 4'd4;
  localparam logic [3:0] S_LWR   = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FEMIT = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [ACTION_W-1:0]   act_q, act_d;
  logic [LINK_W-1:0]     lnk_q, lnk_d;
  logic [GW-1:0]         grp_q, grp_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         pidx_q, pidx_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic                  pend_q, pend_d;
  logic [STATUS_W-1:0]   st_q, st_d;
  logic                  hit_any_q, hit_any_d;
  logic [NUM_GROUPS-1:0] cvld_q, cvld_d;

  logic grp_ok;
  logic lnk_ok;
  logic more;
  logic hit;

  function automatic logic [MAW-1:0] addr_of(input logic [GW-1:0] g, input logic [CW-1:0] i);
    return MAW'(32'(g) * GROUP_CAPACITY + 32'(i));
  endfunction

  assign grp_ok = 32'(group_i) < NUM_GROUPS;
  assign lnk_ok = 32'(link_i) < NUM_LINKS;
  assign more   = idx_q < cnt_q;
  // The shared comparator: the word read last cycle against the link in hand.
  assign hit    = pend_q && (m_rdata_i == lnk_q);

  assign in_stall_o = (state_q != S_IDLE);
  assign c_addr_o   = grp_q;

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    lnk_d     = lnk_q;
    grp_d     = grp_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    st_d      = st_q;
    hit_any_d = hit_any_q;
    cvld_d    = cvld_q;
    emit_o    = '0;
    m_we_o    = 1'b0;
    m_waddr_o = addr_of(grp_q, cnt_q);
    m_wdata_o = lnk_q;
    m_re_o    = 1'b0;
    m_raddr_o = addr_of(grp_q, idx_q);
    c_we_o    = 1'b0;
    c_wdata_o = cnt_q + CW'(1);
    c_re_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_i;
          lnk_d     = link_i;
          grp_d     = GW'(group_i);
          hit_any_d = 1'b0;
          state_d   = S_CNT;
          case (action_i)
            ACT_JOIN: begin
              if (!grp_ok || !lnk_ok) begin
                st_d    = ST_FULL;
                state_d = S_EMIT;
              end
            end
            ACT_LEAVE: begin
              if (!grp_ok || !lnk_ok) begin
                st_d    = ST_NOTMEM;
                state_d = S_EMIT;
              end
            end
            ACT_FAN: begin
              if (!grp_ok) begin
                st_d    = ST_EMPTY;
                state_d = S_EMIT;
              end
            end
            ACT_PURGE: begin
              grp_d = '0;
              if (!lnk_ok) begin
                st_d    = ST_NOTMEM;
                state_d = S_EMIT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_CNT: begin
        c_re_o  = 1'b1;
        state_d = S_CNTW;
      end

      S_CNTW: begin
        cnt_d  = cvld_q[grp_q] ? c_rdata_i : '0;
        idx_d  = '0;
        pend_d = 1'b0;
        if (act_q == ACT_FAN) begin
          if (cnt_d == '0) begin
            st_d    = ST_EMPTY;
            state_d = S_EMIT;
          end else begin
            state_d = S_FRD;
          end
        end else begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit) begin
          pos_d  = pidx_q;
          pend_d = 1'b0;
          if (act_q == ACT_JOIN) begin
            st_d    = ST_ALREADY;
            state_d = S_EMIT;
          end else begin
            state_d = S_LRD;
          end
        end else if (!pend_q && !more) begin
          // Whole row seen without a match.
          case (act_q)
            ACT_JOIN: begin
              if (cnt_q >= CW'(GROUP_CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                m_we_o        = 1'b1;
                c_we_o        = 1'b1;
                cvld_d[grp_q] = 1'b1;
                st_d          = ST_ADDED;
              end
              state_d = S_EMIT;
            end
            ACT_LEAVE: begin
              st_d    = ST_NOTMEM;
              state_d = S_EMIT;
            end
            default: begin
              state_d = S_NEXT;
            end
          endcase
        end else begin
          m_re_o = more;
          pend_d = more;
          pidx_d = idx_q;
          idx_d  = more ? idx_q + CW'(1) : idx_q;
        end
      end

      S_LRD: begin
        m_re_o    = 1'b1;
        m_raddr_o = addr_of(grp_q, cnt_q - CW'(1));
        state_d   = S_LWR;
      end

      S_LWR: begin
        // The row's last member fills the freed slot.
        m_we_o        = 1'b1;
        m_waddr_o     = addr_of(grp_q, pos_q);
        m_wdata_o     = m_rdata_i;
        c_we_o        = 1'b1;
        c_wdata_o     = cnt_q - CW'(1);
        cvld_d[grp_q] = 1'b1;
        if (act_q == ACT_LEAVE) begin
          st_d    = ST_REMOVED;
          state_d = S_EMIT;
        end else begin
          hit_any_d = 1'b1;
          state_d   = S_NEXT;
        end
      end

      S_NEXT: begin
        if (grp_q == GW'(NUM_GROUPS - 1)) begin
          st_d    = hit_any_q ? ST_REMOVED : ST_NOTMEM;
          state_d = S_EMIT;
        end else begin
          grp_d   = grp_q + GW'(1);
          state_d = S_CNT;
        end
      end

      S_FRD: begin
        m_re_o  = 1'b1;
        state_d = S_FEMIT;
      end

      S_FEMIT: begin
        if (out_free_i) begin
          emit_o.vld         = 1'b1;
          emit_o.status      = ST_MEMBER;
          emit_o.member_link = m_rdata_i;
          emit_o.last        = (idx_q == cnt_q - CW'(1));
          if (emit_o.last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_FRD;
          end
        end
      end

      S_EMIT: begin
        if (out_free_i) begin
          emit_o.vld    = 1'b1;
          emit_o.status = st_q;
          emit_o.last   = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      hit_any_q <= 1'b0;
      cvld_q    <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      hit_any_q <= hit_any_d;
      cvld_q    <= cvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    lnk_q  <= lnk_d;
    grp_q  <= grp_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    pidx_q <= pidx_d;
    pos_q  <= pos_d;
    st_q   <= st_d;
  end

endmodule

`default_nettype wire

>>> rtl/mcgt_checker.sv
// Port-level assertion checker for the multicast group membership table, with its bind.
`default_nettype none

`include "multicast_group_membership_table_defines.svh"

module mcgt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [mcgt_pkg::STATUS_W-1:0] status_o,
  input logic [mcgt_pkg::LINK_W-1:0]   member_link_o,
  input logic                          last_o
);
  import mcgt_pkg::*;

  logic                     held;
  logic                     lone_word;
  logic [STATUS_W+LINK_W:0] out_word;

  assign held      = out_valid_o && out_stall_i;
  assign lone_word = out_valid_o && (status_o != ST_MEMBER);
  assign out_word  = {status_o, member_link_o, last_o};

  // A stalled result word holds still.
  `MCGT_ASSERT(a_out_hold, held |=> out_valid_o && $stable(out_word), "stalled result word changed")

  // Only a member word carries a link handle.
  `MCGT_ASSERT(a_link_zero, lone_word |-> member_link_o == '0, "link handle on a non-member word")

  // Every answer other than a member word is the only word of its item.
  `MCGT_ASSERT(a_single_last, lone_word |-> last_o, "single answer without last")

  // While a fan out is still listing members, no new item can enter.
  `MCGT_ASSERT(a_fan_busy, out_valid_o && !last_o |-> in_stall_o, "input open during a fan out")

  // After reset is sampled, no result is pending and the input is open.
  `MCGT_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o && !in_stall_o, "activity during reset")

endmodule

bind multicast_group_membership_table mcgt_checker u_mcgt_checker (.*);

`default_nettype wire
